// File: rtl/csks_pkg.sv
// Shared types, constants and helpers for the clipped keyed sprite scaler.
package csks_pkg;

    // Coordinate field width and derived arithmetic widths
    localparam int C = 12;
    localparam int N = C + 1;   // quotients, sums of two coordinates
    localparam int W = C + 3;   // clip arithmetic, holds start + len

    localparam int ADDR_W = 5;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SRC_SIZE  = 3'd0;
    localparam logic [2:0] REG_DST_ORIG  = 3'd1;
    localparam logic [2:0] REG_DST_SIZE  = 3'd2;
    localparam logic [2:0] REG_CLIP_H    = 3'd3;
    localparam logic [2:0] REG_CLIP_V    = 3'd4;
    localparam logic [2:0] REG_TRANS_KEY = 3'd5;

    localparam logic [8:0] KEY_NONE = 9'd256;

    typedef struct packed {
        logic [7:0] pixel;
        logic       first_of_image;
    } t_in_item;

    typedef struct packed {
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [12:0] out_width;
        logic [12:0] out_height;
        logic [7:0]  out_pixel;
    } t_out_item;

    typedef struct packed {
        logic [C-1:0] sw;
        logic [C-1:0] sh;
        logic [C-1:0] dx;
        logic [C-1:0] dy;
        logic [C-1:0] dw;
        logic [C-1:0] dh;
        logic [C-1:0] cl;
        logic [C-1:0] cr;
        logic [C-1:0] ct;
        logic [C-1:0] cb;
        logic [8:0]   key;
    } t_cfg;

    // Which quotient the shared divider is producing
    typedef enum logic [1:0] {
        DIV_COL,
        DIV_ROW,
        DIV_K
    } t_div_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     eval;
        logic     write;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic         ok;
        logic [W-1:0] s;
        logic [W-1:0] l;
    } t_span;

    // Clip a span [start, start+len-1] to the inclusive window [lo, hi]
    function automatic t_span clip_span(input logic [W-1:0] start,
                                        input logic [W-1:0] len,
                                        input logic [C-1:0] lo,
                                        input logic [C-1:0] hi);
        logic [W-1:0] e_end;
        logic [W-1:0] s;
        logic [W-1:0] e;
        t_span        r;
        e_end = start + len - W'(1);
        s     = (start > W'(lo)) ? start : W'(lo);
        e     = (e_end < W'(hi)) ? e_end : W'(hi);
        r.ok  = (len != '0) && (s <= e);
        r.s   = s;
        r.l   = e - s + W'(1);
        return r;
    endfunction

endpackage

// File: rtl/csks_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module csks_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [csks_pkg::N-1:0]    i_num,
    input  logic [csks_pkg::C-1:0]    i_den,
    output logic                      o_done,
    output logic [csks_pkg::N-1:0]    o_quot,
    output logic [csks_pkg::C-1:0]    o_rem
);

    localparam int CNT_W = $clog2(csks_pkg::N);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [csks_pkg::C:0]      r_rem;
    logic [csks_pkg::N-1:0]    r_quot;
    logic [csks_pkg::C-1:0]    r_den;

    logic [csks_pkg::C:0]      w_shift;
    logic                      w_ge;

    // Trial subtract of the shifted partial remainder
    assign w_shift = {r_rem[csks_pkg::C-1:0], r_quot[csks_pkg::N-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(csks_pkg::N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient register shifts numerator bits out and quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quot <= {r_quot[csks_pkg::N-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[csks_pkg::C-1:0];

endmodule

// File: rtl/csks_dp.sv
// Datapath: stepping state, quotients, rectangle build, clipping, output register.
module csks_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  csks_pkg::t_cfg       i_cfg,
    input  csks_pkg::t_cmd       i_cmd,
    output csks_pkg::t_sts       o_sts,
    input  csks_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    output csks_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall
);

    localparam int C = csks_pkg::C;
    localparam int N = csks_pkg::N;
    localparam int W = csks_pkg::W;
    localparam int M = N + C;

    // Stepping state
    logic [C-1:0] r_src_col, r_src_row, r_dcc, r_drc, r_ca, r_ra, r_nsc, r_nsr;
    logic [C-1:0] n_src_col, n_src_row, n_dcc, n_drc, n_ca, n_ra, n_nsc, n_nsr;

    // Current item and quotients
    logic [7:0]   r_pix;
    logic [N-1:0] r_cols, r_rows, r_k;
    logic [C-1:0] r_crem, r_rrem;

    // Candidate rectangle
    logic         r_hit;
    logic [N-1:0] r_x0, r_y0, r_w0, r_h0;
    logic         n_hit;
    logic [N-1:0] n_x0, n_y0, n_w0, n_h0;

    logic                r_out_valid;
    csks_pkg::t_out_item r_out;

    // Divider hookup
    logic [N-1:0] w_num, w_quot;
    logic [C-1:0] w_den, w_rem;
    logic         w_done;

    logic         w_valid, w_mode1, w_mode2, w_dnz, w_row_end;
    logic [N-1:0] w_k, w_wc, w_hc, w_dw_left, w_dh_left;
    logic         w_sel_c, w_sel_r;
    logic [M-1:0] w_ksh;
    logic [N-1:0] w_ca_sum, w_ra_sum;
    csks_pkg::t_span w_spx, w_spy;
    logic         w_emit, w_out_free;

    assign w_valid = (i_cfg.sw != '0) && (i_cfg.sh != '0) &&
                     (r_src_col < i_cfg.sw) && (r_src_row < i_cfg.sh);
    assign w_mode1 = i_cfg.sw < i_cfg.dw;
    assign w_mode2 = i_cfg.sw > i_cfg.dw;
    assign w_dnz   = (i_cfg.dw != '0) && (i_cfg.dh != '0);

    // Operand select for the shared divider
    always_comb begin
        case (i_cmd.div_sel)
            csks_pkg::DIV_COL: begin
                w_num = w_mode1 ? {1'b0, i_cfg.dw} : {1'b0, i_cfg.sw};
                w_den = w_mode1 ? i_cfg.sw : i_cfg.dw;
            end
            csks_pkg::DIV_ROW: begin
                w_num = w_mode1 ? {1'b0, i_cfg.dh} : {1'b0, i_cfg.sh};
                w_den = w_mode1 ? i_cfg.sh : i_cfg.dh;
            end
            csks_pkg::DIV_K: begin
                w_num = {1'b0, i_cfg.dh} - {1'b0, r_ra} + {1'b0, i_cfg.sh} - N'(1);
                w_den = i_cfg.sh;
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    csks_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // Rectangle extents for the current pixel
    assign w_k       = ((r_rows == '0) && (r_ra < i_cfg.dh)) ? r_k : N'(1);
    assign w_ca_sum  = {1'b0, r_ca} + {1'b0, r_crem};
    assign w_ra_sum  = {1'b0, r_ra} + {1'b0, r_rrem};
    assign w_wc      = r_cols + N'(w_ca_sum >= {1'b0, i_cfg.sw});
    assign w_hc      = r_rows + N'(w_ra_sum >= {1'b0, i_cfg.sh});
    assign w_dw_left = {1'b0, i_cfg.dw} - {1'b0, r_dcc};
    assign w_dh_left = {1'b0, i_cfg.dh} - {1'b0, r_drc};
    assign w_sel_c   = (r_src_col == r_nsc) && (r_dcc < i_cfg.dw);
    assign w_sel_r   = (r_src_row == r_nsr) && (r_drc < i_cfg.dh);
    assign w_row_end = ({1'b0, r_src_col} + N'(1)) >= {1'b0, i_cfg.sw};
    assign w_ksh     = w_k * i_cfg.sh;

    always_comb begin
        n_x0 = '0;
        n_y0 = '0;
        n_w0 = '0;
        n_h0 = '0;
        if (w_mode1) begin
            n_x0 = {1'b0, i_cfg.dx} + {1'b0, r_dcc};
            n_y0 = {1'b0, i_cfg.dy} + {1'b0, r_drc};
            n_w0 = (r_dcc >= i_cfg.dw) ? '0 : ((w_wc < w_dw_left) ? w_wc : w_dw_left);
            n_h0 = (r_drc >= i_cfg.dh) ? '0 : ((w_hc < w_dh_left) ? w_hc : w_dh_left);
        end else if (w_mode2) begin
            if (w_dnz) begin
                n_x0 = {1'b0, i_cfg.dx} + {1'b0, r_dcc};
                n_y0 = {1'b0, i_cfg.dy} + {1'b0, r_drc};
                n_w0 = N'(w_sel_c);
                n_h0 = w_sel_r ? ((w_k < w_dh_left) ? w_k : w_dh_left) : '0;
            end
        end else begin
            n_x0 = {1'b0, i_cfg.dx} + {1'b0, r_src_col};
            n_y0 = {1'b0, i_cfg.dy} + {1'b0, r_src_row};
            n_w0 = N'(1);
            n_h0 = N'(1);
        end
        n_hit = w_valid && (i_cfg.key[8] || (r_pix != i_cfg.key[7:0]));
    end

    // Next stepping state
    always_comb begin
        logic [N-1:0] ca_t, ra_t, step;
        logic [M-1:0] ra_m;
        n_src_col = r_src_col;
        n_src_row = r_src_row;
        n_dcc     = r_dcc;
        n_drc     = r_drc;
        n_ca      = r_ca;
        n_ra      = r_ra;
        n_nsc     = r_nsc;
        n_nsr     = r_nsr;
        ca_t      = '0;
        ra_t      = '0;
        step      = '0;
        ra_m      = '0;
        if (w_valid && w_mode1) begin
            ca_t  = (w_ca_sum >= {1'b0, i_cfg.sw}) ? (w_ca_sum - {1'b0, i_cfg.sw}) : w_ca_sum;
            n_ca  = ca_t[C-1:0];
            ca_t  = {1'b0, r_dcc} + w_wc;
            n_dcc = ca_t[C-1:0];
            if (w_row_end && (i_cfg.dh != '0)) begin
                ra_t  = (w_ra_sum >= {1'b0, i_cfg.sh}) ? (w_ra_sum - {1'b0, i_cfg.sh})
                                                       : w_ra_sum;
                n_ra  = ra_t[C-1:0];
                ra_t  = {1'b0, r_drc} + w_hc;
                n_drc = ra_t[C-1:0];
            end
        end else if (w_valid && w_mode2 && w_dnz) begin
            if (w_sel_c) begin
                n_dcc = r_dcc + C'(1);
                ca_t  = {1'b0, r_ca} + {1'b0, r_crem};
                step  = r_cols;
                if (ca_t >= {1'b0, i_cfg.dw}) begin
                    ca_t = ca_t - {1'b0, i_cfg.dw};
                    step = step + N'(1);
                end
                n_ca  = ca_t[C-1:0];
                step  = {1'b0, r_nsc} + step;
                n_nsc = step[C-1:0];
            end
            if (w_row_end && w_sel_r) begin
                if (r_rows != '0) begin
                    n_drc = r_drc + C'(1);
                    ra_t  = {1'b0, r_ra} + {1'b0, r_rrem};
                    step  = r_rows;
                    if (ra_t >= {1'b0, i_cfg.dh}) begin
                        ra_t = ra_t - {1'b0, i_cfg.dh};
                        step = step + N'(1);
                    end
                    n_ra  = ra_t[C-1:0];
                    step  = {1'b0, r_nsr} + step;
                    n_nsr = step[C-1:0];
                end else begin
                    ra_t  = {1'b0, r_drc} + w_k;
                    n_drc = ra_t[C-1:0];
                    ra_m  = M'(r_ra) + w_ksh - M'(i_cfg.dh);
                    n_ra  = (r_ra < i_cfg.dh) ? ra_m[C-1:0] : '0;
                    n_nsr = r_nsr + C'(1);
                end
            end
        end
        // End of a source row restarts the column state
        if (w_row_end) begin
            n_src_col = '0;
            n_dcc     = '0;
            n_ca      = '0;
            n_nsc     = '0;
            if (r_src_row < i_cfg.sh) n_src_row = r_src_row + C'(1);
        end else begin
            n_src_col = r_src_col + C'(1);
        end
    end

    // Stepping state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_dcc     <= '0;
            r_drc     <= '0;
            r_ca      <= '0;
            r_ra      <= '0;
            r_nsc     <= '0;
            r_nsr     <= '0;
        end else if (i_cmd.load && i_in_data.first_of_image) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_dcc     <= '0;
            r_drc     <= '0;
            r_ca      <= '0;
            r_ra      <= '0;
            r_nsc     <= '0;
            r_nsr     <= '0;
        end else if (i_cmd.eval) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_dcc     <= n_dcc;
            r_drc     <= n_drc;
            r_ca      <= n_ca;
            r_ra      <= n_ra;
            r_nsc     <= n_nsc;
            r_nsr     <= n_nsr;
        end
    end

    // Item, quotient and candidate payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_pix <= i_in_data.pixel;
        if (w_done) begin
            case (i_cmd.div_sel)
                csks_pkg::DIV_COL: begin
                    r_cols <= w_quot;
                    r_crem <= w_rem;
                end
                csks_pkg::DIV_ROW: begin
                    r_rows <= w_quot;
                    r_rrem <= w_rem;
                end
                csks_pkg::DIV_K: r_k <= w_quot;
                default: ;
            endcase
        end
        if (i_cmd.eval) begin
            r_hit <= n_hit;
            r_x0  <= n_x0;
            r_y0  <= n_y0;
            r_w0  <= n_w0;
            r_h0  <= n_h0;
        end
    end

    // Clip and hand the rectangle to the output register
    assign w_spx      = csks_pkg::clip_span(W'(r_x0), W'(r_w0), i_cfg.cl, i_cfg.cr);
    assign w_spy      = csks_pkg::clip_span(W'(r_y0), W'(r_h0), i_cfg.ct, i_cfg.cb);
    assign w_emit     = r_hit && w_spx.ok && w_spy.ok;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Set on a new rectangle, hold while stalled, clear after a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.write && w_out_free && w_emit) ||
                           (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && w_out_free && w_emit) begin
            r_out.out_x      <= w_spx.s[11:0];
            r_out.out_y      <= w_spy.s[11:0];
            r_out.out_width  <= w_spx.l[12:0];
            r_out.out_height <= w_spy.l[12:0];
            r_out.out_pixel  <= r_pix;
        end
    end

    assign o_sts.div_done = w_done;
    assign o_sts.out_free = w_out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// File: rtl/csks_ctrl.sv
// Controller: sequences accept, three divisions, evaluation and output write.
module csks_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_busy,
    output csks_pkg::t_cmd  o_cmd,
    input  csks_pkg::t_sts  i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_COL,
        S_DIV_ROW,
        S_DIV_K,
        S_EVAL,
        S_WRITE
    } t_state;

    t_state             r_state;
    logic               r_div_start;
    csks_pkg::t_div_sel r_div_sel;
    logic               r_eval;
    logic               r_write;
    logic               w_load;

    assign w_load = i_in_valid && (r_state == S_IDLE);

    // State and registered commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_div_sel   <= csks_pkg::DIV_COL;
            r_eval      <= 1'b0;
            r_write     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_eval      <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        r_state     <= S_DIV_COL;
                        r_div_start <= 1'b1;
                        r_div_sel   <= csks_pkg::DIV_COL;
                    end
                end
                S_DIV_COL: begin
                    if (i_sts.div_done) begin
                        r_state     <= S_DIV_ROW;
                        r_div_start <= 1'b1;
                        r_div_sel   <= csks_pkg::DIV_ROW;
                    end
                end
                S_DIV_ROW: begin
                    if (i_sts.div_done) begin
                        r_state     <= S_DIV_K;
                        r_div_start <= 1'b1;
                        r_div_sel   <= csks_pkg::DIV_K;
                    end
                end
                S_DIV_K: begin
                    if (i_sts.div_done) begin
                        r_state <= S_EVAL;
                        r_eval  <= 1'b1;
                    end
                end
                S_EVAL: begin
                    r_state <= S_WRITE;
                    r_write <= 1'b1;
                end
                S_WRITE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_write <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy          = r_state != S_IDLE;
    assign o_cmd.load      = w_load;
    assign o_cmd.div_start = r_div_start;
    assign o_cmd.div_sel   = r_div_sel;
    assign o_cmd.eval      = r_eval;
    assign o_cmd.write     = r_write;

endmodule

// File: rtl/clipped_keyed_sprite_scaler_core.sv
// Top level of the clipped keyed sprite scaler: register file and core wiring.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (pixel, first)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (rectangle)
//  config  | input     | APB psel/penable/pwrite | pwdata -> 6 registers
//
// For each pixel the shared bit-serial divider runs three times (column ratio, row
// ratio, row span); the rectangle is then built and registered, and after that it
// is clipped and written to the output register.
// Synchronous active-low reset clears stepping state and config to defaults.
// A waiting result does not block the next pixel; only the final write waits
// for the output register to free up.
module clipped_keyed_sprite_scaler_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  csks_pkg::t_in_item                i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output csks_pkg::t_out_item               o_out_data,
    input  logic                              i_out_stall,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csks_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int C = csks_pkg::C;

    logic [2*C-1:0] r_src_size, r_dst_orig, r_dst_size, r_clip_h, r_clip_v;
    logic [8:0]     r_key;
    logic [2:0]     w_idx;
    logic           w_wr;

    csks_pkg::t_cfg w_cfg;
    csks_pkg::t_cmd w_cmd;
    csks_pkg::t_sts w_sts;
    logic           w_busy;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_size <= '0;
            r_dst_orig <= '0;
            r_dst_size <= '0;
            r_clip_h   <= '0;
            r_clip_v   <= '0;
            r_key      <= csks_pkg::KEY_NONE;
        end else if (w_wr) begin
            case (w_idx)
                csks_pkg::REG_SRC_SIZE:  r_src_size <= pwdata[2*C-1:0];
                csks_pkg::REG_DST_ORIG:  r_dst_orig <= pwdata[2*C-1:0];
                csks_pkg::REG_DST_SIZE:  r_dst_size <= pwdata[2*C-1:0];
                csks_pkg::REG_CLIP_H:    r_clip_h   <= pwdata[2*C-1:0];
                csks_pkg::REG_CLIP_V:    r_clip_v   <= pwdata[2*C-1:0];
                csks_pkg::REG_TRANS_KEY: r_key      <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            csks_pkg::REG_SRC_SIZE:  prdata = 32'(r_src_size);
            csks_pkg::REG_DST_ORIG:  prdata = 32'(r_dst_orig);
            csks_pkg::REG_DST_SIZE:  prdata = 32'(r_dst_size);
            csks_pkg::REG_CLIP_H:    prdata = 32'(r_clip_h);
            csks_pkg::REG_CLIP_V:    prdata = 32'(r_clip_v);
            csks_pkg::REG_TRANS_KEY: prdata = 32'(r_key);
            default:                 prdata = '0;
        endcase
    end

    assign w_cfg.sw  = r_src_size[C-1:0];
    assign w_cfg.sh  = r_src_size[2*C-1:C];
    assign w_cfg.dx  = r_dst_orig[C-1:0];
    assign w_cfg.dy  = r_dst_orig[2*C-1:C];
    assign w_cfg.dw  = r_dst_size[C-1:0];
    assign w_cfg.dh  = r_dst_size[2*C-1:C];
    assign w_cfg.cl  = r_clip_h[C-1:0];
    assign w_cfg.cr  = r_clip_h[2*C-1:C];
    assign w_cfg.ct  = r_clip_v[C-1:0];
    assign w_cfg.cb  = r_clip_v[2*C-1:C];
    assign w_cfg.key = r_key;

    assign o_in_stall = w_busy;

    csks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    csks_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: rtl/csks_chk.sv
// Port-level checker for the sprite scaler, bound to the top level.
module csks_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input csks_pkg::t_out_item          o_out_data,
    input logic                         i_out_stall
);

    // Held result does not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // An accepted pixel keeps the input side stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // A new result appears only while a pixel is in progress
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a pixel in progress");

    // Clipped rectangles are never empty and never exceed the coordinate range
    a_rect_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_width != '0) && (o_out_data.out_height != '0) &&
                        (!o_out_data.out_width[12] || (o_out_data.out_width[11:0] == '0)) &&
                        (!o_out_data.out_height[12] || (o_out_data.out_height[11:0] == '0)))
        else $error("bad rectangle size");

endmodule

bind clipped_keyed_sprite_scaler_core csks_chk u_csks_chk (.*);
